[rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and codes for the point-in-polygon test block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // Default sizing
  localparam int unsigned DefMaxVertices = 256;
  localparam int unsigned DefCoordBits   = 16;

  // Fixed stream field widths
  localparam int unsigned CoordFieldW = 16;
  localparam int unsigned KindW       = 2;
  localparam int unsigned InTdataW    = 2 * CoordFieldW;
  localparam int unsigned OutTdataW   = 8;

  // Request kinds; code 3 carries no meaning and answers with zeros
  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

endpackage

`default_nettype wire

[rtl/pip_edge_pipe.sv]
// ----------------------------------------------------------------------------
// pip_edge_pipe
// Three-stage edge crossing test: order the edge by y and form differences,
// multiply across, then compare and fold the hit into a parity bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_pipe #(
  parameter int unsigned CoordBits = pip_pkg::DefCoordBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clr_i,     // start of a new query
  input  wire logic                     vld_i,     // one edge this cycle
  input  wire logic [2*CoordBits-1:0]   a_i,       // {y, x} of first vertex
  input  wire logic [2*CoordBits-1:0]   b_i,       // {y, x} of second vertex
  input  wire logic [CoordBits-1:0]     qx_i,
  input  wire logic [CoordBits-1:0]     qy_i,
  output logic                          busy_o,
  output logic                          parity_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [CoordBits-1:0] ax, ay, bx, by;
  logic signed [CoordBits-1:0] lo_x, lo_y, hi_x, hi_y, qx, qy, x_max;
  logic                        hit_d;

  logic                 e_vld_q, e_hit_q;
  logic signed [DW-1:0] e_d1_q, e_d2_q, e_d3_q, e_d4_q;
  logic signed [DW-1:0] e_d1_d, e_d2_d, e_d3_d, e_d4_d;

  logic                 m_vld_q, m_hit_q;
  logic signed [PW-1:0] m_p1_q, m_p2_q, m_p1_d, m_p2_d;

  logic parity_q;

  assign ax = signed'(a_i[CoordBits-1:0]);
  assign ay = signed'(a_i[2*CoordBits-1:CoordBits]);
  assign bx = signed'(b_i[CoordBits-1:0]);
  assign by = signed'(b_i[2*CoordBits-1:CoordBits]);
  assign qx = signed'(qx_i);
  assign qy = signed'(qy_i);

  always_comb begin
    if (ay > by) begin
      lo_x = bx; lo_y = by; hi_x = ax; hi_y = ay;
    end else begin
      lo_x = ax; lo_y = ay; hi_x = bx; hi_y = by;
    end
    x_max = (ax > bx) ? ax : bx;
    // half-open y span also rules out horizontal edges
    hit_d = (qy > lo_y) && (qy <= hi_y) && (qx <= x_max);
    e_d1_d = DW'(qx)   - DW'(lo_x);
    e_d2_d = DW'(hi_y) - DW'(lo_y);
    e_d3_d = DW'(qy)   - DW'(lo_y);
    e_d4_d = DW'(hi_x) - DW'(lo_x);
  end

  // x <= lo_x + d3*d4/d2 with d2 > 0, cross-multiplied
  assign m_p1_d = e_d1_q * e_d2_q;
  assign m_p2_d = e_d3_q * e_d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q  <= 1'b0;
      m_vld_q  <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      e_vld_q <= vld_i;
      m_vld_q <= e_vld_q;
      if (clr_i) begin
        parity_q <= 1'b0;
      end else if (m_vld_q && m_hit_q && (m_p1_q <= m_p2_q)) begin
        parity_q <= ~parity_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_hit_q <= hit_d;
    e_d1_q  <= e_d1_d;
    e_d2_q  <= e_d2_d;
    e_d3_q  <= e_d3_d;
    e_d4_q  <= e_d4_d;
    m_hit_q <= e_hit_q;
    m_p1_q  <= m_p1_d;
    m_p2_q  <= m_p2_d;
  end

  assign busy_o   = e_vld_q | m_vld_q;
  assign parity_o = parity_q;

endmodule

`default_nettype wire

[rtl/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting point-in-polygon test over a vertex list kept in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the request kind (clear, append, query),
//   tdata carries the x and y coordinate. Every request gives exactly one
//   response on the output stream: bit 0 inside flag, bit 1 store-full flag.
//   The caller closes the polygon by appending the first vertex again.
// Timing:
//   Clear, append, the unused kind and a query on fewer than two vertices
//   go from accept straight to the finish state, which, once the output
//   register is free, loads the response into it and returns to idle. A
//   query over N >= 2 stored vertices first reads each vertex in the scan
//   state and waits in the drain state for the pipeline to empty: the
//   vertex memory has a single read port, so edges are streamed one per
//   cycle into a three-stage crossing pipeline. One request is in work at a time.
// Reset clears the vertex count and all control state; memory contents are
// left as they are and are never read before being written.
// A stalled output holds the response in the output register; the block
// takes one more request, holds its response until the register frees and
// accepts nothing new meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test #(
  parameter int unsigned MaxVertices = pip_pkg::DefMaxVertices,
  parameter int unsigned CoordBits   = pip_pkg::DefCoordBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [pip_pkg::InTdataW-1:0]   s_axis_tdata_i,  // coord_x, coord_y
  input  wire logic [pip_pkg::KindW-1:0]      s_axis_tuser_i,  // kind
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [pip_pkg::OutTdataW-1:0]       m_axis_tdata_o   // inside_res, status
);

  localparam int unsigned AW   = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned VW   = 2 * CoordBits;
  localparam int unsigned FW   = pip_pkg::CoordFieldW;
  localparam int unsigned ExtW = (CoordBits > FW) ? CoordBits : FW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [VW-1:0] mem [MaxVertices];
  logic [VW-1:0] rdata_q, prev_q;
  logic          rd_vld_q, rd_first_q;

  logic [CntW-1:0] count_q, count_d, count_m1;
  logic [AW-1:0]   scan_addr_q, scan_addr_d;

  logic [CoordBits-1:0] in_x, in_y, qx_q, qy_q;
  logic [ExtW-1:0]      x_ext, y_ext;

  logic accept, full, mem_we, mem_re, edge_clr, edge_busy, parity;
  logic res_inside_q, res_inside_d, res_status_q, res_status_d;
  logic out_vld_q, out_inside_q, out_status_q;
  logic out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // low CoordBits of the 16-bit field, two's complement
  assign x_ext = ExtW'(s_axis_tdata_i[FW-1:0]);
  assign y_ext = ExtW'(s_axis_tdata_i[2*FW-1:FW]);
  assign in_x  = x_ext[CoordBits-1:0];
  assign in_y  = y_ext[CoordBits-1:0];

  assign full     = (count_q == CntW'(MaxVertices));
  assign count_m1 = count_q - CntW'(1);
  assign out_free = ~out_vld_q | m_axis_tready_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_addr_d  = scan_addr_q;
    res_inside_d = res_inside_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    edge_clr     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_inside_d = 1'b0;
          res_status_d = 1'b0;
          state_d      = ST_FINISH;
          case (s_axis_tuser_i)
            pip_pkg::KIND_CLEAR: begin
              count_d = '0;
            end
            pip_pkg::KIND_APPEND: begin
              if (full) begin
                res_status_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            pip_pkg::KIND_QUERY: begin
              edge_clr    = 1'b1;
              scan_addr_d = '0;
              if (count_q >= CntW'(2)) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (scan_addr_q == count_m1[AW-1:0]) begin
          state_d = ST_DRAIN;
        end else begin
          scan_addr_d = scan_addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !edge_busy) begin
          res_inside_d = parity;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_vld_q   <= mem_re;
      rd_first_q <= mem_re && (scan_addr_q == '0);
      if (state_q == ST_FINISH && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q  <= scan_addr_d;
    res_inside_q <= res_inside_d;
    res_status_q <= res_status_d;
    if (accept) begin
      qx_q <= in_x;
      qy_q <= in_y;
    end
    if (rd_vld_q) begin
      prev_q <= rdata_q;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_inside_q <= res_inside_q;
      out_status_q <= res_status_q;
    end
  end

  // vertex store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {in_y, in_x};
    end
    if (mem_re) begin
      rdata_q <= mem[scan_addr_q];
    end
  end

  pip_edge_pipe #(
    .CoordBits (CoordBits)
  ) u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (edge_clr),
    .vld_i    (rd_vld_q & ~rd_first_q),
    .a_i      (prev_q),
    .b_i      (rdata_q),
    .qx_i     (qx_q),
    .qy_i     (qy_q),
    .busy_o   (edge_busy),
    .parity_o (parity)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(pip_pkg::OutTdataW - 2)'(0), out_status_q, out_inside_q};

endmodule

`default_nettype wire
